>>> rtl/core/pocsag_codeword_framer_macros.svh
// Assertion macros used by the framer checker.
`ifndef POCSAG_CODEWORD_FRAMER_MACROS_SVH
`define POCSAG_CODEWORD_FRAMER_MACROS_SVH

// Implication into the next cycle.
`define PCF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("framer assertion failed");

// Implication in the same cycle.
`define PCF_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("framer assertion failed");

`endif

>>> rtl/core/pcf_pkg.sv
`default_nettype none
package pcf_pkg;

    localparam int SLOTS_PER_BATCH = 16;
    localparam int SLOT_W          = 5;
    localparam int CNT_W           = 5;
    localparam int PC_W            = 4;
    localparam int ADDR_W          = 3;
    localparam int REG_IDX_W       = 1;

    localparam logic [31:0] SYNC_WORD       = 32'h7CD215D8;
    localparam logic [31:0] IDLE_WORD       = 32'h7A89C197;
    localparam logic [31:0] PREAMBLE_WORD   = 32'hAAAAAAAA;
    localparam logic [31:0] BCH_GEN_ALIGNED = 32'hED200000;

    localparam logic [REG_IDX_W-1:0] REG_PREAMBLE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_INVERT   = 1'd1;

    localparam logic [PC_W-1:0] PC_HOME = 4'd0;
    localparam logic [PC_W-1:0] PC_MSG  = 4'd6;

    localparam logic [4:0] PREAMBLE_RESET = 5'd20;

    // Word source for an emitted item
    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_PRE  = 3'd1,
        SRC_SYNC = 3'd2,
        SRC_IDLE = 3'd3,
        SRC_CODE = 3'd4
    } t_src;

    typedef enum logic [2:0] {
        M_WAIT     = 3'd0,
        M_ONCE     = 3'd1,
        M_CNT_LOOP = 3'd2,
        M_PAD_LOOP = 3'd3,
        M_IF_FULL  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CL_NONE  = 2'd0,
        CL_PRE   = 2'd1,
        CL_FRAME = 2'd2
    } t_cnt_ld;

    typedef enum logic [1:0] {
        SO_NONE = 2'd0,
        SO_ADDR = 2'd1,
        SO_INC  = 2'd2
    } t_slot_op;

    typedef enum logic [1:0] {
        LS_NO        = 2'd0,
        LS_YES       = 2'd1,
        LS_NOT_FINAL = 2'd2
    } t_last_sel;

    typedef enum logic [1:0] {
        JC_NEXT      = 2'd0,
        JC_ALWAYS    = 2'd1,
        JC_KIND      = 2'd2,
        JC_NOT_FINAL = 2'd3
    } t_jump;

    typedef struct packed {
        t_mode            mode;
        t_src             src;
        t_cnt_ld          cnt_ld;
        t_slot_op         slot_op;
        t_last_sel        last;
        t_jump            jump;
        logic [PC_W-1:0]  tgt;
    } t_uop;

    typedef struct packed {
        logic       in_valid;
        logic       kind;
        logic       final_word;
        logic [2:0] frame;
        logic [4:0] preamble_words;
        logic       out_free;
    } t_seq_in;

    typedef struct packed {
        logic in_ready;
        logic emit;
        t_src src;
        logic last;
    } t_seq_out;

    // Microcode program
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{M_ONCE, SRC_NONE, CL_NONE, SO_NONE, LS_NO, JC_ALWAYS, PC_HOME};
        case (pc)
            4'd0: u = '{M_WAIT,     SRC_NONE, CL_NONE,  SO_NONE, LS_NO,
                        JC_KIND,      PC_MSG};
            4'd1: u = '{M_ONCE,     SRC_NONE, CL_PRE,   SO_NONE, LS_NO,
                        JC_NEXT,      PC_HOME};
            4'd2: u = '{M_CNT_LOOP, SRC_PRE,  CL_NONE,  SO_NONE, LS_NO,
                        JC_NEXT,      PC_HOME};
            4'd3: u = '{M_ONCE,     SRC_SYNC, CL_FRAME, SO_NONE, LS_NO,
                        JC_NEXT,      PC_HOME};
            4'd4: u = '{M_CNT_LOOP, SRC_IDLE, CL_NONE,  SO_NONE, LS_NO,
                        JC_NEXT,      PC_HOME};
            4'd5: u = '{M_ONCE,     SRC_CODE, CL_NONE,  SO_ADDR, LS_YES,
                        JC_ALWAYS,    PC_HOME};
            4'd6: u = '{M_IF_FULL,  SRC_SYNC, CL_NONE,  SO_NONE, LS_NO,
                        JC_NEXT,      PC_HOME};
            4'd7: u = '{M_ONCE,     SRC_CODE, CL_NONE,  SO_INC,  LS_NOT_FINAL,
                        JC_NOT_FINAL, PC_HOME};
            4'd8: u = '{M_PAD_LOOP, SRC_IDLE, CL_NONE,  SO_NONE, LS_NO,
                        JC_NEXT,      PC_HOME};
            4'd9: u = '{M_ONCE,     SRC_IDLE, CL_NONE,  SO_NONE, LS_YES,
                        JC_ALWAYS,    PC_HOME};
            default: u = '{M_ONCE, SRC_NONE, CL_NONE, SO_NONE, LS_NO,
                           JC_ALWAYS, PC_HOME};
        endcase
        return u;
    endfunction

    // Check bits contributed by each of the 21 data bits (codeword bits 31..11)
    typedef logic [20:0][9:0] t_bch_cols;

    function automatic t_bch_cols bch_cols_calc();
        t_bch_cols   cols;
        logic [31:0] rem;
        for (int k = 0; k < 21; k++) begin
            rem = 32'h1 << (11 + k);
            for (int i = 0; i < 21; i++) begin
                if (rem[31]) begin
                    rem = rem ^ BCH_GEN_ALIGNED;
                end
                rem = rem << 1;
            end
            cols[k] = rem[31:22];
        end
        return cols;
    endfunction

    localparam t_bch_cols BCH_COLS = bch_cols_calc();

endpackage
`default_nettype wire

>>> rtl/core/pocsag_codeword_framer.sv
`default_nettype none
// A message item passes the batch-full step (a sync word if the batch is full) before its
//   codeword is registered; a start item sends preamble words, sync, 2*frame idles, then its address.
// One item at a time: a new item is taken only once the sequencer is back home; with
//   final_word a message is followed by idles that pad the batch, then a last idle. Each
//   counted loop spends a step with no output when its count runs out; i_out_ready stalls hold it.
// Synchronous active-low reset: sequencer at home, batch slot 0, preamble 20, no inversion.
module pocsag_codeword_framer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_kind,
    input  wire logic [20:0]                i_pager_address,
    input  wire logic [1:0]                 i_function_bits,
    input  wire logic [19:0]                i_payload,
    input  wire logic                       i_final_word,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [31:0]                     o_codeword,
    output logic                            o_last_of_run,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pcf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [4:0]  r_preamble_words;
    logic        r_invert;
    logic        r_kind;
    logic [20:0] r_addr;
    logic [1:0]  r_func;
    logic [19:0] r_payload;
    logic        r_final;
    logic        r_out_valid;
    logic [31:0] r_codeword;
    logic        r_last;

    pcf_pkg::t_seq_in  seq_in;
    pcf_pkg::t_seq_out seq_out;

    logic [20:0]                 code_data;
    logic [31:0]                 code_word;
    logic [31:0]                 word;
    logic                        cfg_wr;
    logic                        in_acc;
    logic [pcf_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign in_acc  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble_words <= pcf_pkg::PREAMBLE_RESET;
            r_invert         <= 1'b0;
        end else if (cfg_wr) begin
            if (reg_idx == pcf_pkg::REG_PREAMBLE) begin
                r_preamble_words <= pwdata[4:0];
            end else if (reg_idx == pcf_pkg::REG_INVERT) begin
                r_invert <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (reg_idx == pcf_pkg::REG_INVERT) begin
            prdata = {31'd0, r_invert};
        end else begin
            prdata = {27'd0, r_preamble_words};
        end
    end

    // Hold the accepted item for the run of codewords it causes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind    <= i_kind;
            r_addr    <= i_pager_address;
            r_func    <= i_function_bits;
            r_payload <= i_payload;
            r_final   <= i_final_word;
        end
    end

    assign seq_in = '{
        in_valid:       i_in_valid,
        kind:           i_kind,
        final_word:     r_final,
        frame:          r_addr[2:0],
        preamble_words: r_preamble_words,
        out_free:       !r_out_valid || i_out_ready
    };

    pcf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_in),
        .o_ctl   (seq_out)
    );

    assign o_in_ready = seq_out.in_ready;

    assign code_data = r_kind ? {1'b1, r_payload} : {1'b0, r_addr[20:3], r_func};

    pcf_bch_enc u_enc (
        .i_data (code_data),
        .o_word (code_word)
    );

    always_comb begin
        case (seq_out.src)
            pcf_pkg::SRC_PRE:  word = pcf_pkg::PREAMBLE_WORD;
            pcf_pkg::SRC_SYNC: word = pcf_pkg::SYNC_WORD;
            pcf_pkg::SRC_IDLE: word = pcf_pkg::IDLE_WORD;
            pcf_pkg::SRC_CODE: word = code_word;
            default:           word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_out.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_out.emit) begin
            r_codeword <= r_invert ? ~word : word;
            r_last     <= seq_out.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_codeword    = r_codeword;
    assign o_last_of_run = r_last;

endmodule
`default_nettype wire

>>> rtl/core/pcf_bch_enc.sv
`default_nettype none
module pcf_bch_enc (
    input  wire logic [20:0] i_data,
    output logic      [31:0] o_word
);

    logic [9:0] chk;

    // The code is linear: XOR the check columns of the set data bits
    always_comb begin
        chk = '0;
        for (int k = 0; k < 21; k++) begin
            if (i_data[k]) begin
                chk = chk ^ pcf_pkg::BCH_COLS[k];
            end
        end
        o_word = {i_data, chk, ^{i_data, chk}};
    end

endmodule
`default_nettype wire

>>> rtl/core/pcf_seq.sv
`default_nettype none
module pcf_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pcf_pkg::t_seq_in  i_ctl,
    output pcf_pkg::t_seq_out      o_ctl
);

    logic [pcf_pkg::PC_W-1:0]   r_pc,   n_pc;
    logic [pcf_pkg::CNT_W-1:0]  r_cnt,  n_cnt;
    logic [pcf_pkg::SLOT_W-1:0] r_slot, n_slot;

    pcf_pkg::t_uop            uop;
    logic                     slot_full;
    logic                     done;
    logic [pcf_pkg::PC_W-1:0] pc_inc;
    logic [pcf_pkg::PC_W-1:0] pc_jump;

    always_comb begin
        uop       = pcf_pkg::uop_rom(r_pc);
        slot_full = (r_slot >= pcf_pkg::SLOT_W'(pcf_pkg::SLOTS_PER_BATCH));
        pc_inc    = r_pc + pcf_pkg::PC_W'(1);

        unique case (uop.jump)
            pcf_pkg::JC_NEXT:      pc_jump = pc_inc;
            pcf_pkg::JC_ALWAYS:    pc_jump = uop.tgt;
            pcf_pkg::JC_KIND:      pc_jump = i_ctl.kind ? uop.tgt : pc_inc;
            pcf_pkg::JC_NOT_FINAL: pc_jump = i_ctl.final_word ? pc_inc : uop.tgt;
            default:               pc_jump = pcf_pkg::PC_HOME;
        endcase

        n_pc           = r_pc;
        n_cnt          = r_cnt;
        n_slot         = r_slot;
        done           = 1'b0;
        o_ctl.in_ready = 1'b0;
        o_ctl.emit     = 1'b0;
        o_ctl.src      = uop.src;

        unique case (uop.last)
            pcf_pkg::LS_YES:       o_ctl.last = 1'b1;
            pcf_pkg::LS_NOT_FINAL: o_ctl.last = !i_ctl.final_word;
            default:               o_ctl.last = 1'b0;
        endcase

        unique case (uop.mode)
            pcf_pkg::M_WAIT: begin
                o_ctl.in_ready = 1'b1;
                done           = i_ctl.in_valid;
            end
            pcf_pkg::M_ONCE: begin
                if (uop.src == pcf_pkg::SRC_NONE) begin
                    done = 1'b1;
                end else if (i_ctl.out_free) begin
                    o_ctl.emit = 1'b1;
                    done       = 1'b1;
                end
            end
            pcf_pkg::M_CNT_LOOP: begin
                // emit while the count lasts, then fall through
                if (r_cnt == '0) begin
                    n_pc = pc_inc;
                end else if (i_ctl.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_cnt      = r_cnt - pcf_pkg::CNT_W'(1);
                end
            end
            pcf_pkg::M_PAD_LOOP: begin
                if (slot_full) begin
                    n_pc = pc_inc;
                end else if (i_ctl.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_slot     = r_slot + pcf_pkg::SLOT_W'(1);
                end
            end
            pcf_pkg::M_IF_FULL: begin
                // sync word only when the batch is full, then restart the batch
                if (!slot_full) begin
                    n_pc = pc_inc;
                end else if (i_ctl.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_slot     = '0;
                    n_pc       = pc_inc;
                end
            end
            default: begin
                n_pc = pcf_pkg::PC_HOME;
            end
        endcase

        if (done) begin
            n_pc = pc_jump;
            unique case (uop.cnt_ld)
                pcf_pkg::CL_PRE:   n_cnt = pcf_pkg::CNT_W'(i_ctl.preamble_words);
                pcf_pkg::CL_FRAME: n_cnt = pcf_pkg::CNT_W'({i_ctl.frame, 1'b0});
                default:           n_cnt = r_cnt;
            endcase
            unique case (uop.slot_op)
                pcf_pkg::SO_ADDR: n_slot = pcf_pkg::SLOT_W'({i_ctl.frame, 1'b1});
                pcf_pkg::SO_INC:  n_slot = r_slot + pcf_pkg::SLOT_W'(1);
                default:          n_slot = n_slot;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= pcf_pkg::PC_HOME;
            r_cnt  <= '0;
            r_slot <= '0;
        end else begin
            r_pc   <= n_pc;
            r_cnt  <= n_cnt;
            r_slot <= n_slot;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/pcf_checker.sv
`default_nettype none
`include "pocsag_codeword_framer_macros.svh"
module pcf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_codeword,
    input wire logic        o_last_of_run
);

    // Every codeword has even parity, inverted or not
    `PCF_ASSERT_NOW(a_even_parity, i_clk, i_rst_n, o_out_valid, (^o_codeword) == 1'b0)

    // One item at a time: the next item waits for the run to finish
    `PCF_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    `PCF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `PCF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_codeword) && $stable(o_last_of_run))

endmodule

bind pocsag_codeword_framer pcf_checker u_pcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_codeword    (o_codeword),
    .o_last_of_run (o_last_of_run)
);
`default_nettype wire
